// ----- sv/shb_pkg.sv -----
// shared types and constants for the string hash bucket unit
`default_nettype none

package shb_pkg;

    localparam int unsigned HASH_W    = 32;
    localparam int unsigned HASH_BITS = 32;
    localparam logic [HASH_W-1:0] HASH_MASK =
        HASH_W'((64'd1 << HASH_BITS) - 64'd1);

    localparam logic [HASH_W-1:0] FNV_BASIS = 32'h811c_9dc5;
    localparam logic [HASH_W-1:0] FNV_PRIME = 32'h0100_0193;

    localparam logic [HASH_W-1:0] MODULUS_RESET = 32'd1;

    // queue between front and back end
    localparam int unsigned FIFO_DEPTH = 2;
    localparam int unsigned FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // one dividend bit per step
    localparam int unsigned DIV_STEPS  = HASH_W;
    localparam int unsigned DIV_STEP_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [HASH_W-1:0] hash_value;
        logic [HASH_W-1:0] bucket_index;
        logic              divide_error;
    } out_item_t;

    // handshake between the queue and the back end
    typedef struct packed {
        logic              valid;
        logic [HASH_W-1:0] hash;
    } queue_head_t;

endpackage

`default_nettype wire

// ----- sv/shb_fifo.sv -----
// small queue of finished string hashes between front and back end
`default_nettype none

module shb_fifo (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              push,
    input  wire logic [shb_pkg::HASH_W-1:0]        push_hash,
    output logic                                   not_full,
    input  wire logic                              pop,
    output shb_pkg::queue_head_t                   head
);

    logic [shb_pkg::HASH_W-1:0]     mem [shb_pkg::FIFO_DEPTH];
    logic [shb_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [shb_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [shb_pkg::FIFO_CNT_W-1:0] count_reg, count_next;
    logic                           do_push, do_pop;

    localparam logic [shb_pkg::FIFO_PTR_W-1:0] PTR_LAST =
        shb_pkg::FIFO_PTR_W'(shb_pkg::FIFO_DEPTH - 1);
    localparam logic [shb_pkg::FIFO_CNT_W-1:0] CNT_FULL =
        shb_pkg::FIFO_CNT_W'(shb_pkg::FIFO_DEPTH);

    assign not_full   = (count_reg != CNT_FULL);
    assign head.valid = (count_reg != '0);
    assign head.hash  = mem[rd_ptr_reg];

    assign do_push = push && not_full;
    assign do_pop  = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_hash;
        end
    end

endmodule

`default_nettype wire

// ----- sv/shb_front.sv -----
// byte front end: running hash, one byte per cycle while the queue is not full, hands finished hashes on
`default_nettype none

module shb_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire shb_pkg::in_item_t          in_item,
    output logic                            push,
    output logic [shb_pkg::HASH_W-1:0]      push_hash,
    input  wire logic                       queue_not_full
);

    logic [shb_pkg::HASH_W-1:0] hash_reg, hash_next;
    logic [shb_pkg::HASH_W-1:0] hash_step;
    logic [shb_pkg::HASH_W-1:0] hash_upd;
    logic                       accept;

    assign in_ready = queue_not_full;
    assign accept   = in_valid && in_ready;

    // multiply by the prime mod 2^32, then add the byte
    assign hash_step = hash_reg * shb_pkg::FNV_PRIME + {24'd0, in_item.data_byte};
    assign hash_upd  = in_item.byte_valid ? hash_step : hash_reg;

    assign push      = accept && in_item.last;
    assign push_hash = hash_upd & shb_pkg::HASH_MASK;

    always_comb
    begin
        hash_next = hash_reg;
        if (accept)
        begin
            hash_next = in_item.last ? shb_pkg::FNV_BASIS : hash_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= shb_pkg::FNV_BASIS;
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/shb_back.sv -----
// back end: modulus register, bit-serial remainder, output register
`default_nettype none

module shb_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [shb_pkg::HASH_W-1:0] cfg_data,
    input  wire shb_pkg::queue_head_t       head,
    output logic                            pop,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output shb_pkg::out_item_t              out_item
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    localparam logic [shb_pkg::DIV_STEP_W-1:0] STEP_LAST =
        shb_pkg::DIV_STEP_W'(shb_pkg::DIV_STEPS - 1);

    state_t                         state_reg, state_next;
    logic [shb_pkg::HASH_W-1:0]     modulus_reg;
    logic [shb_pkg::DIV_STEP_W-1:0] step_reg, step_next;
    logic                           out_valid_reg, out_valid_next;
    shb_pkg::out_item_t             out_item_reg, out_item_next;
    logic [shb_pkg::HASH_W-1:0]     hash_reg, hash_next;
    logic [shb_pkg::HASH_W-1:0]     dividend_reg, dividend_next;
    logic [shb_pkg::HASH_W-1:0]     rem_reg, rem_next;
    logic                           err_reg, err_next;
    logic [shb_pkg::HASH_W:0]       trial;
    logic [shb_pkg::HASH_W:0]       trial_diff;
    logic                           mod_zero;

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign mod_zero  = (modulus_reg == '0);

    // restoring step: shift in next dividend bit, subtract if it fits
    assign trial      = {rem_reg, dividend_reg[shb_pkg::HASH_W-1]};
    assign trial_diff = trial - {1'b0, modulus_reg};

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        hash_next      = hash_reg;
        dividend_next  = dividend_reg;
        rem_next       = rem_reg;
        err_next       = err_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg && !out_ready;
        pop            = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop           = 1'b1;
                    hash_next     = head.hash;
                    dividend_next = head.hash;
                    rem_next      = '0;
                    step_next     = '0;
                    err_next      = mod_zero;
                    state_next    = mod_zero ? ST_DONE : ST_DIV;
                end
            end
            ST_DIV:
            begin
                dividend_next = dividend_reg << 1;
                rem_next      = trial_diff[shb_pkg::HASH_W] ?
                                trial[shb_pkg::HASH_W-1:0] :
                                trial_diff[shb_pkg::HASH_W-1:0];
                step_next     = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next             = 1'b1;
                    out_item_next.hash_value   = hash_reg;
                    out_item_next.bucket_index = err_reg ? '0 : rem_reg;
                    out_item_next.divide_error = err_reg;
                    state_next                 = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            modulus_reg   <= shb_pkg::MODULUS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                modulus_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg     <= hash_next;
        dividend_reg <= dividend_next;
        rem_reg      <= rem_next;
        err_reg      <= err_next;
        out_item_reg <= out_item_next;
    end

endmodule

`default_nettype wire

// ----- sv/string_hash_bucket_top.sv -----
// top level of the string hash bucket unit
//
// channel  direction  payload               transaction
// in       input      shb_pkg::in_item_t    one byte item (in_valid & in_ready)
// out      output     shb_pkg::out_item_t   one hash and bucket (out_valid & out_ready)
// cfg      input      32-bit modulus        register write (cfg_valid & cfg_ready)
//
// bytes are taken one per cycle while the queue is not full; one constant multiply each
// the back end works out one string at a time in 32 remainder steps, one bit each
// a zero modulus skips the remainder steps
// a two-entry queue holds finished hashes; in_ready drops only while it is full
// reset: running hash to the offset basis, modulus to 1, queue empty, no result
`default_nettype none

module string_hash_bucket_top (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire shb_pkg::in_item_t          in_item,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output shb_pkg::out_item_t              out_item,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [shb_pkg::HASH_W-1:0] cfg_data
);

    logic                       push;
    logic [shb_pkg::HASH_W-1:0] push_hash;
    logic                       queue_not_full;
    logic                       pop;
    shb_pkg::queue_head_t       head;

    shb_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_item        (in_item),
        .push           (push),
        .push_hash      (push_hash),
        .queue_not_full (queue_not_full)
    );

    shb_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_hash (push_hash),
        .not_full  (queue_not_full),
        .pop       (pop),
        .head      (head)
    );

    shb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    a_err_bucket_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && out_item.divide_error |-> out_item.bucket_index == '0
    ) else $error("bucket index not zero on divide error");

    a_bucket_le_hash: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.bucket_index <= out_item.hash_value
    ) else $error("bucket index exceeds hash");

    a_hash_masked: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.hash_value & ~shb_pkg::HASH_MASK) == '0
    ) else $error("hash has bits above the mask");

    a_pop_needs_head: assert property (
        @(posedge clk) disable iff (!rst_n)
        pop |-> head.valid
    ) else $error("back end pops an empty queue");

endmodule

`default_nettype wire

// ----- bench/tb_string_hash_bucket_top.sv -----
// self-checking bench for the string hash bucket unit: directed strings then random traffic
`default_nettype none

module tb_string_hash_bucket_top;

    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned CHUNK_ITEMS  = 100;
    localparam logic [31:0] KEEP_MASK =
        (shb_pkg::HASH_BITS >= 32) ? 32'hFFFF_FFFF :
        (shb_pkg::HASH_BITS == 0)  ? 32'h0 : ((32'd1 << shb_pkg::HASH_BITS) - 32'd1);
    localparam logic [31:0] OFFSET_BASIS = 32'h811c_9dc5;
    localparam logic [31:0] MULT_PRIME   = 32'h0100_0193;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    shb_pkg::in_item_t   in_item;
    logic                out_valid;
    logic                out_ready;
    shb_pkg::out_item_t  out_item;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [31:0]         cfg_data;

    // model state
    logic [31:0]         hash_acc;
    logic [31:0]         modulus_shadow;
    shb_pkg::out_item_t  pending_buckets[$];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned cycle_count;
    int unsigned fail_count;
    int unsigned strings_seen;
    int unsigned bytes_seen;
    int unsigned ignored_seen;
    int unsigned modulus_writes;
    int unsigned zero_mod_results;

    string_hash_bucket_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // fold one accepted byte transaction into the running hash
    task automatic fold_string_item(input shb_pkg::in_item_t it);
        shb_pkg::out_item_t res;
        logic [31:0]        masked;
        if (it.byte_valid)
        begin
            hash_acc = hash_acc * MULT_PRIME + {24'd0, it.data_byte};
            bytes_seen++;
        end
        else if (!it.last)
            ignored_seen++;
        if (it.last)
        begin
            masked = hash_acc & KEEP_MASK;
            res.hash_value = masked;
            if (modulus_shadow == 32'd0)
            begin
                res.bucket_index = 32'd0;
                res.divide_error = 1'b1;
                zero_mod_results++;
            end
            else
            begin
                res.bucket_index = masked % modulus_shadow;
                res.divide_error = 1'b0;
            end
            pending_buckets.push_back(res);
            hash_acc = OFFSET_BASIS;
            strings_seen++;
        end
    endtask

    task automatic check_bucket_result(input shb_pkg::out_item_t got);
        shb_pkg::out_item_t want;
        if (pending_buckets.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected result: hash %h bucket %h err %b",
                         got.hash_value, got.bucket_index, got.divide_error);
            return;
        end
        want = pending_buckets.pop_front();
        if (got.hash_value !== want.hash_value || got.bucket_index !== want.bucket_index
            || got.divide_error !== want.divide_error)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("mismatch: hash exp %h got %h, bucket exp %h got %h, err exp %b got %b",
                         want.hash_value, got.hash_value, want.bucket_index,
                         got.bucket_index, want.divide_error, got.divide_error);
        end
    endtask

    // sample every handshake at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                modulus_shadow = cfg_data;
                modulus_writes++;
            end
            if (in_valid && in_ready)
                fold_string_item(in_item);
            if (out_valid && out_ready)
                check_bucket_result(out_item);
        end
    end

    // entered and left at a falling edge
    task automatic send_item(input logic [7:0] data, input logic valid, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{data_byte: data, byte_valid: valid, last: last};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // hold off input until every result is back and the back end is quiet
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_buckets.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_modulus(input logic [31:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // returns the number of counted items (bytes, or one for an empty string)
    task automatic send_random_string(output int unsigned counted);
        int unsigned len;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 6)
            len = 0;
        else if (pick < 85)
            len = $urandom_range(1, 10);
        else if (pick < 97)
            len = $urandom_range(11, 30);
        else
            len = $urandom_range(31, 64);
        if (len == 0)
        begin
            send_item(8'($urandom_range(255)), 1'b0, 1'b1);
            counted = 1;
            return;
        end
        for (int unsigned i = 0; i < len; i++)
        begin
            // occasional byte-less filler inside the string
            if ($urandom_range(99) < 8)
                send_item(8'($urandom_range(255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(255)), 1'b1, (i == len - 1));
        end
        counted = len;
    endtask

    function automatic logic [31:0] pick_modulus();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(1, 16);
            3: return 32'd1 << $urandom_range(31);
            4: return $urandom_range(17, 5000);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_reset_modulus();
        // modulus is 1 out of reset, so buckets are all zero
        send_item(8'h61, 1'b1, 1'b1);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
    endtask

    task automatic test_empty_string();
        send_item(8'hFF, 1'b0, 1'b1);
    endtask

    task automatic test_byte_extremes();
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        repeat (3) send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1);
    endtask

    task automatic test_ignored_bytes();
        send_item(8'h5A, 1'b1, 1'b0);
        send_item(8'hA5, 1'b0, 1'b0);
        send_item(8'h3C, 1'b1, 1'b0);
        // byte-less last item emits what was collected
        send_item(8'hC3, 1'b0, 1'b1);
    endtask

    task automatic test_zero_modulus();
        write_modulus(32'd0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h7E, 1'b1, 1'b1);
    endtask

    task automatic test_modulus_extremes();
        write_modulus(32'hFFFF_FFFF);
        send_item(8'h01, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b1);
        write_modulus(32'h8000_0000);
        send_item(8'hFE, 1'b1, 1'b0);
        send_item(8'h7F, 1'b1, 1'b1);
        write_modulus(32'd7);
        send_item(8'h10, 1'b1, 1'b0);
        send_item(8'hEF, 1'b1, 1'b1);
    endtask

    task automatic test_random_traffic();
        int unsigned in_chunk;
        int unsigned n;
        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    send_idle_pct = 11;
                    recv_idle_pct = 52;
                end
                1:
                begin
                    send_idle_pct = 52;
                    recv_idle_pct = 11;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            repeat (5)
            begin
                write_modulus(pick_modulus());
                in_chunk = 0;
                while (in_chunk < CHUNK_ITEMS)
                begin
                    send_random_string(n);
                    in_chunk += n;
                end
            end
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        in_item          = '0;
        cfg_valid        = 1'b0;
        cfg_data         = '0;
        send_idle_pct    = 11;
        recv_idle_pct    = 52;
        cycle_count      = 0;
        fail_count       = 0;
        strings_seen     = 0;
        bytes_seen       = 0;
        ignored_seen     = 0;
        modulus_writes   = 0;
        zero_mod_results = 0;
        hash_acc         = OFFSET_BASIS;
        modulus_shadow   = shb_pkg::MODULUS_RESET;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_modulus();
        test_empty_string();
        test_byte_extremes();
        test_ignored_bytes();
        test_zero_modulus();
        test_modulus_extremes();
        test_random_traffic();

        wait_drained();
        $display("run covered %0d strings, %0d bytes and %0d byte-less fillers",
                 strings_seen, bytes_seen, ignored_seen);
        $display("across %0d modulus writes, %0d results with a zero modulus",
                 modulus_writes, zero_mod_results);
        if (fail_count == 0 && pending_buckets.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
